/* rtl/guillotine_rect_packer_assert.svh */
// Assertion macros for the guillotine packer checker.
// No dependencies; included by rtl/grp_checker.sv.
`ifndef GUILLOTINE_RECT_PACKER_ASSERT_SVH
`define GUILLOTINE_RECT_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/grp_pkg.sv */
// Shared types, sizes and codes for the guillotine rectangle packer.
// No dependencies; imported by every module of the block.
package grp_pkg;

    localparam int MAX_FREE   = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_FREE);
    localparam int CNT_W      = $clog2(MAX_FREE + 1);
    localparam int AREA_W     = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AREA_W-1:0]     area_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_t;

    // Result status codes
    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_FAILED  = 3'd3;
    localparam logic [2:0] ST_STARTED = 3'd4;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_X = 2'd0;
    localparam logic [1:0] REG_Y = 2'd1;
    localparam logic [1:0] REG_W = 2'd2;
    localparam logic [1:0] REG_H = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_SEED,
        OP_REMOVE,
        OP_SPLIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        idx_t     bi;
        cnt_t     cnt;
        cnt_t     cnt_m1;
    } cell_ctl_t;

    typedef struct packed {
        logic  found;
        idx_t  bi;
        rect_t entry;
    } scan_res_t;

endpackage

/* rtl/grp_cell.sv */
// One cell of the free-rectangle chain: holds one entry, loads from its neighbor, the head, the seed or a split piece.
// Depends on grp_pkg.
module grp_cell (
    input  logic              clk,
    input  grp_pkg::idx_t     idx,
    input  grp_pkg::cell_ctl_t ctl,
    input  grp_pkg::rect_t    nxt,
    input  grp_pkg::rect_t    head,
    input  grp_pkg::rect_t    seed,
    input  grp_pkg::rect_t    c1,
    input  grp_pkg::rect_t    c2,
    output grp_pkg::rect_t    ent
);
    import grp_pkg::*;

    rect_t ent_reg;
    rect_t ent_next;
    cnt_t  my_cnt;

    assign my_cnt = CNT_W'(idx);
    assign ent    = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
                ent_next = ent_reg;
            end
            OP_ROT:
            begin
                // last live entry wraps to the head
                ent_next = (my_cnt == ctl.cnt_m1) ? head : nxt;
            end
            OP_SEED:
            begin
                if (idx == '0)
                    ent_next = seed;
            end
            OP_REMOVE:
            begin
                if (idx >= ctl.bi)
                    ent_next = nxt;
            end
            OP_SPLIT:
            begin
                if (my_cnt == ctl.cnt_m1)
                    ent_next = c2;
                else if (my_cnt == ctl.cnt)
                    ent_next = c1;
                else if (idx >= ctl.bi)
                    ent_next = nxt;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

/* rtl/grp_scan.sv */
// Best-area-fit evaluator at the head of the chain: fit test, area, running minimum.
// Depends on grp_pkg.
module grp_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               issue,
    input  grp_pkg::rect_t     head,
    input  grp_pkg::coord_t    rw,
    input  grp_pkg::coord_t    rh,
    input  grp_pkg::area_t     tarea,
    output grp_pkg::scan_res_t res
);
    import grp_pkg::*;

    idx_t  idx_reg;
    logic  v1_reg;
    logic  fit1_reg;
    area_t prod1_reg;
    rect_t ent1_reg;
    idx_t  idx1_reg;
    logic  found_reg;
    area_t best_reg;
    idx_t  bi_reg;
    rect_t be_reg;
    area_t d;
    logic  take;

    assign d    = prod1_reg - tarea;
    assign take = v1_reg && fit1_reg && (!found_reg || (d < best_reg));

    assign res = '{found: found_reg, bi: bi_reg, entry: be_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            if (issue)
                idx_reg <= idx_reg + 1'b1;
            if (take)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            fit1_reg  <= (rh <= head.h) && (rw <= head.w);
            prod1_reg <= head.w * head.h;
            ent1_reg  <= head;
            idx1_reg  <= idx_reg;
        end
        if (take)
        begin
            best_reg <= d;
            bi_reg   <= idx1_reg;
            be_reg   <= ent1_reg;
        end
    end

endmodule

/* rtl/guillotine_rect_packer.sv */
// Top level of the guillotine rectangle packer (best-area-fit free list).
// Depends on grp_pkg, grp_cell, grp_scan.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, command, rect_w/h      | beat in
//  out     | out_valid/out_ready, status, pos, count   | beat out
//  cfg     | APB psel/penable/pwrite/paddr/pwdata      | regs r/w
//
// A start, or a place after a failure, answers in the cycle after its beat.
// A place runs an area step, a search pass, a drain step and a decide step;
// a split starts the next pass straight from the decide step. Each pass
// rotates the cell chain one entry per cycle past the evaluator at its head.
// Reset sets control and config registers; entries read only below the count.
// A stalled result beat holds the block in its final step; a new input beat
// is taken while the previous result waits only if out_ready frees the slot.
module guillotine_rect_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] rect_width,
    input  logic [15:0] rect_height,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [6:0]  free_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import grp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_AREA   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_DECIDE = 6'b010000,
        S_SPARE  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    logic       failed_reg, failed_next;
    idx_t       k_reg, k_next;
    coord_t     rw_reg, rh_reg;
    area_t      tarea_reg;
    logic [14:0] rx_reg, ry_reg;
    logic [15:0] rwid_reg, rhei_reg;

    logic        ov_reg, ov_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] px_reg, px_next;
    logic [15:0] py_reg, py_next;
    logic [6:0]  fc_reg, fc_next;

    cell_ctl_t  ctl;
    cell_op_t   cell_op;
    rect_t      ent [MAX_FREE];
    rect_t      nxt [MAX_FREE];
    rect_t      seed, c1, c2, e;
    scan_res_t  sres;
    logic       scan_start, issue, accept, can_out, exact;
    coord_t     hd, wd;

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign can_out   = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign free_count = fc_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg   <= '0;
            ry_reg   <= '0;
            rwid_reg <= 16'd1024;
            rhei_reg <= 16'd1024;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_X:   rx_reg   <= pwdata[14:0];
                REG_Y:   ry_reg   <= pwdata[14:0];
                REG_W:   rwid_reg <= pwdata[15:0];
                REG_H:   rhei_reg <= pwdata[15:0];
                default: rx_reg   <= rx_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_X:   prdata = {17'd0, rx_reg};
            REG_Y:   prdata = {17'd0, ry_reg};
            REG_W:   prdata = {16'd0, rwid_reg};
            REG_H:   prdata = {16'd0, rhei_reg};
            default: prdata = '0;
        endcase
    end

    // Seed entry from the region registers, taken modulo the coordinate range
    assign seed = '{x: COORD_BITS'(rx_reg), y: COORD_BITS'(ry_reg),
                    w: COORD_BITS'(rwid_reg), h: COORD_BITS'(rhei_reg)};

    // Split of the best entry along the axis with the larger leftover
    assign e     = sres.entry;
    assign hd    = e.h - rh_reg;
    assign wd    = e.w - rw_reg;
    assign exact = (e.w == rw_reg) && (e.h == rh_reg);

    always_comb
    begin
        if (hd > wd)
        begin
            c1 = '{x: e.x, y: e.y, w: e.w, h: rh_reg};
            c2 = '{x: e.x, y: e.y + rh_reg, w: e.w, h: hd};
        end
        else
        begin
            c1 = '{x: e.x, y: e.y, w: rw_reg, h: e.h};
            c2 = '{x: e.x + rw_reg, y: e.y, w: wd, h: e.h};
        end
    end

    // Cell chain: each cell loads from its right neighbor; last wraps to head
    for (genvar i = 0; i < MAX_FREE; i++)
    begin : g_cell
        if (i == MAX_FREE - 1)
        begin : g_last
            assign nxt[i] = ent[0];
        end
        else
        begin : g_mid
            assign nxt[i] = ent[i + 1];
        end
        grp_cell u_cell (
            .clk  (clk),
            .idx  (IDX_W'(i)),
            .ctl  (ctl),
            .nxt  (nxt[i]),
            .head (ent[0]),
            .seed (seed),
            .c1   (c1),
            .c2   (c2),
            .ent  (ent[i])
        );
    end

    grp_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .issue (issue),
        .head  (ent[0]),
        .rw    (rw_reg),
        .rh    (rh_reg),
        .tarea (tarea_reg),
        .res   (sres)
    );

    assign ctl = '{op: cell_op, bi: sres.bi, cnt: cnt_reg, cnt_m1: cnt_reg - 1'b1};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        failed_next = failed_reg;
        k_next      = k_reg;
        ov_next     = ov_reg && !out_ready;
        st_next     = st_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        fc_next     = fc_reg;
        cell_op     = OP_HOLD;
        scan_start  = 1'b0;
        issue       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_START)
                    begin
                        cell_op     = OP_SEED;
                        cnt_next    = CNT_W'(1);
                        failed_next = 1'b0;
                        ov_next     = 1'b1;
                        st_next     = ST_STARTED;
                        px_next     = '0;
                        py_next     = '0;
                        fc_next     = 7'(CNT_W'(1));
                    end
                    else if (failed_reg)
                    begin
                        ov_next = 1'b1;
                        st_next = ST_FAILED;
                        px_next = '0;
                        py_next = '0;
                        fc_next = 7'(cnt_reg);
                    end
                    else
                    begin
                        state_next = S_AREA;
                    end
                end
            end
            S_AREA:
            begin
                scan_start = 1'b1;
                k_next     = '0;
                state_next = (cnt_reg == '0) ? S_DRAIN : S_SCAN;
            end
            S_SCAN:
            begin
                issue   = 1'b1;
                cell_op = OP_ROT;
                k_next  = k_reg + 1'b1;
                if (CNT_W'(k_reg) == ctl.cnt_m1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last candidate meets the running minimum here
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!sres.found)
                begin
                    if (can_out)
                    begin
                        failed_next = 1'b1;
                        ov_next     = 1'b1;
                        st_next     = ST_NOFIT;
                        px_next     = '0;
                        py_next     = '0;
                        fc_next     = 7'(cnt_reg);
                        state_next  = S_IDLE;
                    end
                end
                else if (exact)
                begin
                    if (can_out)
                    begin
                        cell_op    = OP_REMOVE;
                        cnt_next   = cnt_reg - 1'b1;
                        ov_next    = 1'b1;
                        st_next    = ST_PLACED;
                        px_next    = 16'(e.x);
                        py_next    = 16'(e.y);
                        fc_next    = 7'(cnt_reg - 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else if (cnt_reg == CNT_W'(MAX_FREE))
                begin
                    if (can_out)
                    begin
                        failed_next = 1'b1;
                        ov_next     = 1'b1;
                        st_next     = ST_OVERFLOW;
                        px_next     = '0;
                        py_next     = '0;
                        fc_next     = 7'(cnt_reg);
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    // drop the entry, append both pieces, search again
                    cell_op    = OP_SPLIT;
                    cnt_next   = cnt_reg + 1'b1;
                    scan_start = 1'b1;
                    k_next     = '0;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            failed_reg <= 1'b0;
            k_reg      <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            failed_reg <= failed_next;
            k_reg      <= k_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        px_reg <= px_next;
        py_reg <= py_next;
        fc_reg <= fc_next;
        if (accept)
        begin
            rw_reg <= COORD_BITS'(rect_width);
            rh_reg <= COORD_BITS'(rect_height);
        end
        if (state_reg == S_AREA)
            tarea_reg <= rw_reg * rh_reg;
    end

endmodule

/* rtl/grp_checker.sv */
// Port-level checker for the guillotine packer, bound to the top level.
// Depends on grp_pkg and guillotine_rect_packer_assert.svh.
`include "guillotine_rect_packer_assert.svh"

module grp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] pos_x,
    input logic [15:0] pos_y,
    input logic [6:0]  free_count
);
    import grp_pkg::*;

    `GRP_ASSERT_NOW(a_pos_zero, out_valid && (status != ST_PLACED), (pos_x == 16'd0) && (pos_y == 16'd0), "position set on a beat that placed nothing")
    `GRP_ASSERT_NEXT(a_start_seed, in_valid && in_ready && (command == CMD_START), out_valid && (status == ST_STARTED) && (free_count == 7'd1), "start beat did not answer with one free entry")
    `GRP_ASSERT_NOW(a_status_code, out_valid, (status == ST_PLACED) || (status == ST_NOFIT) || (status == ST_OVERFLOW) || (status == ST_FAILED) || (status == ST_STARTED), "status code out of range")
    `GRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(free_count), "stalled result beat changed")

endmodule

bind guillotine_rect_packer grp_checker u_grp_checker (.*);
